// ===== rtl/core/dynamic_slicing_dp_unit_assert.svh =====
// Assertion helpers for the core modules; only the back module includes them.
`ifndef DYNAMIC_SLICING_DP_UNIT_ASSERT_SVH
`define DYNAMIC_SLICING_DP_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSDP_ASSERT_HOLD(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dsdp_pkg.sv =====
package dsdp_pkg;

    localparam int CAT_W   = 3;
    localparam int PEN_W   = 32;
    localparam int MCL_W   = 13;
    localparam int LL_W    = 48;
    localparam int SC_W    = 13;
    localparam int F_W     = 48;
    localparam int SCORE_W = 64;

    // ln(2) in Q.30.
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    localparam logic signed [SCORE_W-1:0] LL_MAX = 64'sh00007FFFFFFFFFFF;
    localparam logic signed [SCORE_W-1:0] LL_MIN = 64'shFFFF800000000000;

    // One classified sample passed from the front to the back.
    typedef struct packed {
        logic [CAT_W-1:0] cat;
        logic             cut;
        logic             drop;
        logic             last;
    } t_qword;

    typedef enum logic [0:0] {
        CFG_PENALTY   = 1'b0,
        CFG_MIN_CLUMP = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        F_SETUP, F_SQUARE, F_LOG_LO, F_LOG_HI, F_LN, F_MUL_LO, F_MUL_HI, F_WRITE, F_DONE
    } t_fill_state;

    typedef enum logic [4:0] {
        B_IDLE, B_PUSH, B_RD_I, B_LD_I, B_RD_J, B_LD_J, B_ACC, B_ADD, B_SUM_A, B_SUM_B,
        B_WR_BEST, B_FIN, B_FIN_A, B_FIN_B, B_FIN_N, B_FIN_M, B_BT, B_BT_W, B_EMIT
    } t_back_state;

endpackage

// ===== rtl/core/dsdp_if.sv =====
interface dsdp_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] category;
    logic       last_sample;

    modport source (output valid, output category, output last_sample, input ready);
    modport sink (input valid, input category, input last_sample, output ready);
endinterface

interface dsdp_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] log_likelihood;
    logic [12:0]        slice_count;
    logic               overflow;

    modport source (output valid, output log_likelihood, output slice_count,
                    output overflow, input ready);
    modport sink (input valid, input log_likelihood, input slice_count,
                  input overflow, output ready);
endinterface

// ===== rtl/core/dsdp_front.sv =====
module dsdp_front #(
    parameter int MAX_SAMPLES = 4096,
    parameter int LEVELS      = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dsdp_in_if.sink         i_in,
    input  logic [12:0]     i_min_clump,
    output logic            o_q_valid,
    output dsdp_pkg::t_qword o_q,
    input  logic            i_q_ready
);
    import dsdp_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int DW = (CW > MCL_W) ? CW : MCL_W;

    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    r_last_cut;
    logic [CAT_W-1:0] r_prev;
    logic [CAT_W-1:0] cat_r;
    logic [MCL_W-1:0] gran;
    logic [CW-1:0]    span;
    logic             full;
    logic             cut;
    logic             accept;

    // Fold out-of-range categories back into the level range.
    always_comb begin
        cat_r = i_in.category;
        for (int s = 0; s < 3; s++) begin
            if (int'(cat_r) >= LEVELS) begin
                cat_r = CAT_W'(int'(cat_r) - LEVELS);
            end
        end
    end

    assign gran   = (i_min_clump == '0) ? MCL_W'(1) : i_min_clump;
    assign full   = (r_idx == CW'(MAX_SAMPLES));
    assign span   = r_idx - r_last_cut;
    assign cut    = !full && (r_idx != '0) && (cat_r != r_prev) && (DW'(span) >= DW'(gran));
    assign accept = i_in.valid && i_q_ready;

    assign i_in.ready = i_q_ready;
    assign o_q_valid  = i_in.valid;
    assign o_q        = '{cat: cat_r, cut: cut, drop: full, last: i_in.last_sample};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_last_cut <= '0;
            r_prev     <= '0;
        end else if (accept) begin
            if (i_in.last_sample) begin
                r_idx      <= '0;
                r_last_cut <= '0;
                r_prev     <= '0;
            end else if (!full) begin
                if (cut) begin
                    r_last_cut <= r_idx;
                end
                r_prev <= cat_r;
                r_idx  <= r_idx + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/dsdp_queue.sv =====
module dsdp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  dsdp_pkg::t_qword i_word,
    output logic             o_ready,
    output logic             o_valid,
    output dsdp_pkg::t_qword o_word,
    input  logic             i_ready
);
    import dsdp_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_qword        r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          push;
    logic          pop;

    assign o_ready = (r_cnt != (AW + 1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_word;
        end
    end

endmodule

// ===== rtl/core/dsdp_clnrom.sv =====
module dsdp_clnrom #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    output logic                                   o_ready,
    input  logic [$clog2(MAX_SAMPLES + 1)-1:0]     i_raddr,
    output logic [dsdp_pkg::F_W-1:0]               o_rdata
);
    import dsdp_pkg::*;

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int NW  = $clog2(CW);
    localparam int LGW = NW + 30;
    localparam int PW  = LGW + 30;
    localparam int QW  = LGW;
    localparam int FPW = CW + QW;

    t_fill_state      r_state;
    t_fill_state      n_state;
    logic [CW-1:0]    r_c;
    logic [NW-1:0]    r_n;
    logic [30:0]      r_x;
    logic [4:0]       r_k;
    logic [29:0]      r_frac;
    logic [PW-1:0]    r_p;
    logic [QW-1:0]    r_lnq;
    logic [FPW-1:0]   r_f;
    logic [F_W-1:0]   r_rdata;
    logic [F_W-1:0]   mem [0:MAX_SAMPLES];

    logic [61:0]               sq;
    logic [31:0]               sq_hi;
    logic [LGW-1:0]            lg;
    logic [47:0]               prod_lo;
    logic [LGW-18+30-1:0]      prod_hi;
    logic [CW+17:0]            mul_lo;
    logic [CW+QW-19:0]         mul_hi;
    logic [CW-1:0]             c_next;
    logic [F_W-1:0]            fval;
    logic                      mem_we;

    assign sq      = r_x * r_x;
    assign sq_hi   = sq[61:30];
    assign lg      = {r_n, r_frac};
    assign prod_lo = lg[17:0] * LN2_Q30;
    assign prod_hi = lg[LGW-1:18] * LN2_Q30;
    assign mul_lo  = r_c * r_lnq[17:0];
    assign mul_hi  = r_c * r_lnq[QW-1:18];
    assign c_next  = r_c + 1'b1;
    assign fval    = F_W'((r_f + FPW'(2 ** 13)) >> 14);

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_SETUP:  n_state = (r_c < CW'(2)) ? F_WRITE : F_SQUARE;
            F_SQUARE: n_state = (r_k == 5'd29) ? F_LOG_LO : F_SQUARE;
            F_LOG_LO: n_state = F_LOG_HI;
            F_LOG_HI: n_state = F_LN;
            F_LN:     n_state = F_MUL_LO;
            F_MUL_LO: n_state = F_MUL_HI;
            F_MUL_HI: n_state = F_WRITE;
            F_WRITE:  n_state = (r_c == CW'(MAX_SAMPLES)) ? F_DONE : F_SETUP;
            F_DONE:   n_state = F_DONE;
            default:  n_state = F_SETUP;
        endcase
    end

    always_comb begin
        mem_we  = (r_state == F_WRITE);
        o_ready = (r_state == F_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_SETUP;
            r_c     <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == F_WRITE && r_c != CW'(MAX_SAMPLES)) begin
                r_c <= c_next;
                if ((c_next >> (int'(r_n) + 1)) != '0) begin
                    r_n <= r_n + 1'b1;
                end
            end
        end
    end

    // Log2 by repeated squaring, then scaling to c*ln(c) in Q32.16.
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_SETUP: begin
                r_x    <= 31'(r_c) << (30 - int'(r_n));
                r_k    <= '0;
                r_frac <= '0;
                r_f    <= '0;
            end
            F_SQUARE: begin
                if (sq_hi[31]) begin
                    r_x    <= sq_hi[31:1];
                    r_frac <= {r_frac[28:0], 1'b1};
                end else begin
                    r_x    <= sq_hi[30:0];
                    r_frac <= {r_frac[28:0], 1'b0};
                end
                r_k <= r_k + 1'b1;
            end
            F_LOG_LO: r_p   <= PW'(prod_lo);
            F_LOG_HI: r_p   <= r_p + (PW'(prod_hi) << 18);
            F_LN:     r_lnq <= QW'((r_p + PW'(2 ** 29)) >> 30);
            F_MUL_LO: r_f   <= FPW'(mul_lo);
            F_MUL_HI: r_f   <= r_f + (FPW'(mul_hi) << 18);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_c] <= fval;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dsdp_back.sv =====
module dsdp_back #(
    parameter int MAX_SAMPLES = 4096,
    parameter int LEVELS      = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [dsdp_pkg::PEN_W-1:0]   i_penalty,
    input  logic                                i_q_valid,
    input  dsdp_pkg::t_qword                    i_q,
    output logic                                o_q_ready,
    input  logic                                i_rom_ready,
    output logic [$clog2(MAX_SAMPLES + 1)-1:0]  o_rom_addr,
    input  logic [dsdp_pkg::F_W-1:0]            i_rom_data,
    dsdp_out_if.source                          o_out
);
    import dsdp_pkg::*;
    `include "dynamic_slicing_dp_unit_assert.svh"

    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int RW   = $clog2(MAX_SAMPLES);
    localparam int LW   = $clog2(LEVELS);
    localparam int ROWW = LEVELS * CW;

    t_back_state r_state;
    t_back_state n_state;

    logic [ROWW-1:0]           r_run;
    logic [CW-1:0]             r_n;
    logic                      r_ovf;
    logic [CW-1:0]             r_k;
    logic [CW-1:0]             r_i;
    logic [CW-1:0]             r_j;
    logic [LW-1:0]             r_u;
    logic [ROWW-1:0]           r_ri;
    logic [ROWW-1:0]           r_rj;
    logic [CW-1:0]             r_sum;
    logic signed [SCORE_W-1:0] r_cand;
    logic signed [SCORE_W-1:0] r_best;
    logic [CW-1:0]             r_cut;
    logic signed [SCORE_W-1:0] r_acc;
    logic [CW-1:0]             r_idx;
    logic [CW-1:0]             r_slices;
    logic [ROWW-1:0]           r_rowq;
    logic signed [SCORE_W-1:0] r_bsq;
    logic [CW-1:0]             r_bcq;
    logic                      r_out_valid;
    logic signed [LL_W-1:0]    r_ll;
    logic [SC_W-1:0]           r_sc;
    logic                      r_ov;

    logic [ROWW-1:0]           rows    [0:MAX_SAMPLES-1];
    logic signed [SCORE_W-1:0] bs_mem  [0:MAX_SAMPLES];
    logic [CW-1:0]             bc_mem  [0:MAX_SAMPLES];

    logic                      pop;
    logic                      row_we;
    logic [CW-1:0]             row_raddr;
    logic [CW-1:0]             im1;
    logic [CW-1:0]             jm1;
    logic [CW-1:0]             d;
    logic [CW-1:0]             ri_u;
    logic [LW-1:0]             lvl;
    logic                      u_last;
    logic                      room;
    logic signed [SCORE_W-1:0] pen64;
    logic signed [SCORE_W-1:0] rom64;
    logic signed [SCORE_W-1:0] cand_f;
    logic signed [LL_W-1:0]    sat;

    assign im1    = r_i - 1'b1;
    assign jm1    = r_j - 1'b1;
    assign ri_u   = r_ri[int'(r_u)*CW +: CW];
    assign d      = ri_u - r_rj[int'(r_u)*CW +: CW];
    assign lvl    = LW'(i_q.cat);
    assign u_last = (r_u == LW'(LEVELS - 1));
    assign room   = (r_k < CW'(MAX_SAMPLES));
    assign pen64  = SCORE_W'(i_penalty);
    assign rom64  = $signed({{(SCORE_W - F_W){1'b0}}, i_rom_data});
    assign cand_f = r_cand - rom64;

    always_comb begin
        if (r_acc > LL_MAX) begin
            sat = LL_MAX[LL_W-1:0];
        end else if (r_acc < LL_MIN) begin
            sat = LL_MIN[LL_W-1:0];
        end else begin
            sat = r_acc[LL_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:    n_state = (pop && i_q.last) ? B_PUSH : B_IDLE;
            B_PUSH:    n_state = B_RD_I;
            B_RD_I:    n_state = B_LD_I;
            B_LD_I:    n_state = B_RD_J;
            B_RD_J:    n_state = B_LD_J;
            B_LD_J:    n_state = B_ACC;
            B_ACC:     n_state = B_ADD;
            B_ADD:     n_state = u_last ? B_SUM_A : B_ACC;
            B_SUM_A:   n_state = B_SUM_B;
            B_SUM_B:   n_state = (r_j == im1) ? B_WR_BEST : B_RD_J;
            B_WR_BEST: n_state = (r_i == r_k) ? B_FIN : B_RD_I;
            B_FIN:     n_state = B_FIN_A;
            B_FIN_A:   n_state = B_FIN_B;
            B_FIN_B:   n_state = u_last ? B_FIN_N : B_FIN_A;
            B_FIN_N:   n_state = B_FIN_M;
            B_FIN_M:   n_state = B_BT;
            B_BT:      n_state = (r_idx == '0) ? B_EMIT : B_BT_W;
            B_BT_W:    n_state = B_BT;
            B_EMIT:    n_state = r_out_valid ? B_EMIT : B_IDLE;
            default:   n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_q_ready  = (r_state == B_IDLE) && i_rom_ready;
        pop        = o_q_ready && i_q_valid;
        row_we     = room && ((pop && i_q.cut) || (r_state == B_PUSH));
        row_raddr  = '0;
        o_rom_addr = '0;
        case (r_state)
            B_RD_I:  row_raddr  = im1;
            B_RD_J:  row_raddr  = jm1;
            B_ACC:   o_rom_addr = d;
            B_SUM_A: o_rom_addr = r_sum;
            B_FIN_A: o_rom_addr = ri_u;
            B_FIN_N: o_rom_addr = r_n;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_run       <= '0;
            r_n         <= '0;
            r_ovf       <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop) begin
                if (i_q.cut && room) begin
                    r_k <= r_k + 1'b1;
                end
                if (i_q.drop) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_run[int'(lvl)*CW +: CW] <= r_run[int'(lvl)*CW +: CW] + 1'b1;
                    r_n <= r_n + 1'b1;
                end
            end
            if (r_state == B_PUSH && room) begin
                r_k <= r_k + 1'b1;
            end
            if (r_state == B_EMIT && !r_out_valid) begin
                r_out_valid <= 1'b1;
                r_run       <= '0;
                r_n         <= '0;
                r_ovf       <= 1'b0;
                r_k         <= '0;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Dynamic program datapath: each level of each candidate slice passes through an accumulate and an add state.
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_PUSH: r_i <= CW'(1);
            B_LD_I: begin
                r_ri <= r_rowq;
                r_j  <= '0;
            end
            B_LD_J: begin
                r_rj   <= (r_j == '0) ? '0 : r_rowq;
                r_cand <= pen64 + ((r_j == '0) ? '0 : r_bsq);
                r_u    <= '0;
                r_sum  <= '0;
            end
            B_ACC: r_sum <= r_sum + d;
            B_ADD: begin
                r_cand <= r_cand + rom64;
                if (!u_last) begin
                    r_u <= r_u + 1'b1;
                end
            end
            B_SUM_B: begin
                if (r_j == '0 || r_best < cand_f) begin
                    r_best <= cand_f;
                    r_cut  <= r_j;
                end
                r_j <= r_j + 1'b1;
            end
            B_WR_BEST: r_i <= r_i + 1'b1;
            B_FIN: begin
                r_acc <= r_best - pen64;
                r_u   <= '0;
            end
            B_FIN_B: begin
                r_acc <= r_acc - rom64;
                if (!u_last) begin
                    r_u <= r_u + 1'b1;
                end
            end
            B_FIN_M: begin
                r_acc    <= r_acc + rom64;
                r_idx    <= r_k;
                r_slices <= '0;
            end
            B_BT: begin
                if (r_idx != '0) begin
                    r_slices <= r_slices + 1'b1;
                end
            end
            B_BT_W: r_idx <= r_bcq;
            B_EMIT: begin
                if (!r_out_valid) begin
                    r_ll <= sat;
                    r_sc <= SC_W'(r_slices);
                    r_ov <= r_ovf;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            rows[r_k[RW-1:0]] <= r_run;
        end
        r_rowq <= rows[row_raddr[RW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_WR_BEST) begin
            bs_mem[r_i] <= r_best;
            bc_mem[r_i] <= r_cut;
        end
        r_bsq <= bs_mem[r_j];
        r_bcq <= bc_mem[r_idx];
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.log_likelihood = r_ll;
    assign o_out.slice_count    = r_sc;
    assign o_out.overflow       = r_ov;

    `DSDP_ASSERT_HOLD(a_cand_order, i_clk, i_rst_n, r_state == B_SUM_B, r_j < r_i,
        "candidate cut is not below its boundary")
    `DSDP_ASSERT_NEXT(a_bt_descends, i_clk, i_rst_n, r_state == B_BT_W,
        r_idx < $past(r_idx), "backtrack index did not descend")
    `DSDP_ASSERT_NEXT(a_emit_loads, i_clk, i_rst_n, r_state == B_EMIT && !r_out_valid,
        r_out_valid && r_state == B_IDLE, "result not loaded into output register")
    `DSDP_ASSERT_HOLD(a_rows_bounded, i_clk, i_rst_n, 1'b1, r_k <= r_n,
        "more boundary rows than samples")

endmodule

// ===== rtl/core/dynamic_slicing_dp_unit.sv =====
// Dynamic slicing dependence detector for one categorical variable.
// Input channel i_in carries one word per sample: its category and a flag that
// marks the last sample of a set. Output channel o_out carries one word per set:
// the maximized log-likelihood minus the one-slice null (signed 48-bit Q32.16), the
// number of slices and an overflow flag for samples dropped beyond capacity.
// The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) sets the slice
// penalty and the minimum clump length; write it only while the block is idle.
// Samples are taken at one per cycle while the queue has room: the front
// classifies each word and a four-entry queue feeds the back, which, while idle
// and once the table is filled, folds one word per cycle into the running counts
// and the boundary-row memory. After the last word the back runs the slicing
// program from its row, score and c*ln(c) memories.
// After reset the c*ln(c) table fills its MAX_SAMPLES+1 entries itself; words
// are queued but not consumed until it is done.
// While the receiver stalls, the result waits in the output register and the
// back goes on with the next set; only a second result holds it, and the queue fills.
module dynamic_slicing_dp_unit #(
    parameter int MAX_SAMPLES = 4096,
    parameter int LEVELS      = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsdp_in_if.sink     i_in,
    dsdp_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import dsdp_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES + 1);

    // Configuration registers; the user must write them only between sets, which the block does not enforce.
    logic signed [PEN_W-1:0] r_penalty;
    logic [MCL_W-1:0]        r_min_clump;

    t_qword           fq_word;
    logic             fq_valid;
    logic             fq_ready;
    t_qword           qb_word;
    logic             qb_valid;
    logic             qb_ready;
    logic             rom_ready;
    logic [CW-1:0]    rom_addr;
    logic [F_W-1:0]   rom_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_penalty   <= '0;
            r_min_clump <= MCL_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PENALTY:   r_penalty   <= i_cfg_data;
                CFG_MIN_CLUMP: r_min_clump <= i_cfg_data[MCL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front decides where clump cuts fall, so the back never has to look back.
    dsdp_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .LEVELS      (LEVELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_min_clump (r_min_clump),
        .o_q_valid   (fq_valid),
        .o_q         (fq_word),
        .i_q_ready   (fq_ready)
    );

    dsdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .i_word  (fq_word),
        .o_ready (fq_ready),
        .o_valid (qb_valid),
        .o_word  (qb_word),
        .i_ready (qb_ready)
    );

    dsdp_clnrom #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_clnrom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_ready (rom_ready),
        .i_raddr (rom_addr),
        .o_rdata (rom_data)
    );

    // The back holds the counts, the boundary rows and the slicing program.
    dsdp_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .LEVELS      (LEVELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_penalty   (r_penalty),
        .i_q_valid   (qb_valid),
        .i_q         (qb_word),
        .o_q_ready   (qb_ready),
        .i_rom_ready (rom_ready),
        .o_rom_addr  (rom_addr),
        .i_rom_data  (rom_data),
        .o_out       (o_out)
    );

endmodule
